/* hdl/rtt_pkg.sv */
// Shared types and constants for the request tag tracker.
// Used by the channel interfaces, the table cell and the top level.
package rtt_pkg;

	// Table size and derived widths
	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_W     = 5;
	localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int TICK_W      = 31;
	localparam int WORD_W      = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PENDING_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_STATUS = 2'd2;

	// Reset values of the configuration registers
	localparam logic [LIMIT_W-1:0] LIMIT_RST   = 5'd16;
	localparam logic [TICK_W-1:0]  TIMEOUT_RST = 31'd1000;

	typedef enum logic [1:0] {
		OP_SEND      = 2'd0,
		OP_RESPONSE  = 2'd1,
		OP_SWEEP     = 2'd2,
		OP_SUPERSEDE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ISSUED    = 3'd0,
		KIND_REFUSED   = 3'd1,
		KIND_COMPLETED = 3'd2,
		KIND_DROPPED   = 3'd3,
		KIND_TIMEOUT   = 3'd4
	} kind_t;

	// Command broadcast to every cell while an item is scanned
	typedef struct packed {
		logic              adv;
		op_t               op;
		logic [WORD_W-1:0] rid;
		logic [WORD_W-1:0] now;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] deadline;
	} cell_cmd_t;

	// Token handed from one cell to the next
	typedef struct packed {
		logic act;
		logic taken;
	} link_t;

	// What the active cell reports back
	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] tag;
	} cell_rpt_t;

endpackage

/* hdl/rtt_ifs.sv */
// Valid/ready channel interfaces of the request tag tracker.
// Depends on rtt_pkg for widths.
interface rtt_req_if;
	import rtt_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [31:0]        api_code;
	logic [31:0]        request_id;
	logic signed [31:0] response_status;
	logic [31:0]        timestamp;

	modport source (output valid, opcode, api_code, request_id, response_status, timestamp,
		input ready);
	modport sink (input valid, opcode, api_code, request_id, response_status, timestamp,
		output ready);
endinterface

interface rtt_rsp_if;
	import rtt_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [31:0]        tag_id;
	logic [31:0]        issued_api;
	logic signed [31:0] result_status;
	logic [31:0]        drop_total;
	logic               last_of_run;

	modport source (output valid, kind, tag_id, issued_api, result_status, drop_total,
		last_of_run, input ready);
	modport sink (input valid, kind, tag_id, issued_api, result_status, drop_total,
		last_of_run, output ready);
endinterface

interface rtt_cfg_if;
	import rtt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rtt_cell.sv */
// One table entry of the tracker: valid bit, tag and deadline.
// Acts when the scan token reaches it and hands the token on. Depends on rtt_pkg.
module rtt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rtt_pkg::cell_cmd_t cmd,
	input  rtt_pkg::link_t     link_in,
	output rtt_pkg::link_t     link_out,
	output rtt_pkg::cell_rpt_t rpt
);
	import rtt_pkg::*;

	logic              valid_q;
	logic              act_q;
	logic              taken_q;
	logic [WORD_W-1:0] tag_q;
	logic [WORD_W-1:0] dl_q;
	logic [WORD_W-1:0] diff;
	logic              expired;
	logic              match;
	logic              hit;

	// expired when now - deadline is zero or positive as a signed value
	assign diff    = cmd.now - dl_q;
	assign expired = ~diff[WORD_W-1];
	assign match   = valid_q && (tag_q == cmd.rid);

	// per-opcode hit decision
	always_comb begin
		unique case (cmd.op)
			OP_SEND:      hit = link_in.act && !link_in.taken && !valid_q;
			OP_RESPONSE:  hit = link_in.act && !link_in.taken && match;
			OP_SWEEP:     hit = link_in.act && valid_q && expired;
			OP_SUPERSEDE: hit = link_in.act && match;
			default:      hit = 1'b0;
		endcase
	end

	assign rpt.hit        = hit;
	assign rpt.tag        = tag_q;
	assign link_out.act   = act_q;
	assign link_out.taken = taken_q;

	// token hand-off and valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
			taken_q <= 1'b0;
		end else if (cmd.adv) begin
			act_q   <= link_in.act;
			taken_q <= link_in.taken | hit;
			if (hit) begin
				valid_q <= (cmd.op == OP_SEND);
			end
		end
	end

	// entry payload, written on claim
	always_ff @(posedge clk) begin
		if (cmd.adv && hit && (cmd.op == OP_SEND)) begin
			tag_q <= cmd.tag;
			dl_q  <= cmd.deadline;
		end
	end

endmodule

/* hdl/request_tag_tracker_with_timeout.sv */
// Top level of the request tag tracker: controller, row of table cells, output register.
// Depends on rtt_pkg, rtt_ifs and rtt_cell.
//
//   channel  direction  handshake     contents
//   req      in         valid/ready   opcode, api_code, request_id, response_status, timestamp
//   rsp      out        valid/ready   kind, tag_id, issued_api, result_status, drop_total, last
//   cfg      in         valid/ready   index, data (register write, always ready)
//
// One item at a time: a token walks the row of TABLE_DEPTH cells, one cell a cycle. With a
// free output an item passes from its transfer to the earliest next transfer through the
// scan, the entry to the finish state and the load of the result.
// A sweep holds the token while a timeout result cannot enter the output register, and the
// finish state waits while the output register is full.
// Reset clears all valid bits and counters and loads the configuration reset values; no clearing pass is needed.
module request_tag_tracker_with_timeout (
	input  logic     clk,
	input  logic     arst_n,
	rtt_req_if.sink   req,
	rtt_rsp_if.source rsp,
	rtt_cfg_if.sink   cfg
);
	import rtt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [LIMIT_W-1:0] limit_q;
	logic [TICK_W-1:0]  tmo_q;
	logic [WORD_W-1:0]  tstat_q;

	// item and bookkeeping registers
	op_t               op_q;
	logic [WORD_W-1:0] api_q;
	logic [WORD_W-1:0] rid_q;
	logic [WORD_W-1:0] rstat_q;
	logic [WORD_W-1:0] now_q;
	logic [WORD_W-1:0] dl_q;
	logic              refused_q;
	logic              act0_q;
	logic              found_q;
	logic              held_q;
	logic [WORD_W-1:0] held_tag_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] next_tag_q;
	logic [WORD_W-1:0] drop_q;

	// output register
	logic              ovalid_q;
	kind_t             okind_q;
	logic [WORD_W-1:0] otag_q;
	logic [WORD_W-1:0] oapi_q;
	logic [WORD_W-1:0] ostat_q;
	logic [WORD_W-1:0] odrop_q;
	logic              olast_q;

	// combinational control
	logic              accept;
	logic              out_free;
	logic              adv;
	logic              push;
	kind_t             pkind;
	logic [WORD_W-1:0] ptag;
	logic [WORD_W-1:0] papi;
	logic [WORD_W-1:0] pstat;
	logic [WORD_W-1:0] pdrop;
	logic              plast;
	logic              bump_tag;
	logic              bump_drop;
	logic              hit_any;
	logic [WORD_W-1:0] hit_tag;
	logic              sweep_hit;
	logic              refuse_now;

	cell_cmd_t cmd;
	link_t     links [TABLE_DEPTH+1];
	cell_rpt_t rpts  [TABLE_DEPTH];

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !ovalid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// refusal decided from the live entry count
	assign refuse_now = (CMP_W'(count_q) >= CMP_W'(limit_q))
		|| (count_q == CNT_W'(TABLE_DEPTH));

	// broadcast command and token entry
	assign cmd.adv      = adv;
	assign cmd.op       = op_q;
	assign cmd.rid      = rid_q;
	assign cmd.now      = now_q;
	assign cmd.tag      = next_tag_q;
	assign cmd.deadline = dl_q;
	assign links[0].act   = act0_q;
	assign links[0].taken = (op_q == OP_SEND) && refused_q;

	// row of cells
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		rtt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (links[g]),
			.link_out (links[g+1]),
			.rpt      (rpts[g])
		);
	end

	// collect the report of the single active cell
	always_comb begin
		hit_any = 1'b0;
		hit_tag = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_any = hit_any | rpts[i].hit;
			hit_tag = hit_tag | (rpts[i].tag & {WORD_W{rpts[i].hit}});
		end
	end
	assign sweep_hit = hit_any && (op_q == OP_SWEEP);

	// sequencer
	always_comb begin
		state_d   = state_q;
		adv       = 1'b0;
		push      = 1'b0;
		pkind     = KIND_TIMEOUT;
		ptag      = '0;
		papi      = '0;
		pstat     = '0;
		pdrop     = drop_q;
		plast     = 1'b0;
		bump_tag  = 1'b0;
		bump_drop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a new timeout pushes the held one out, so the output must be free
				adv = !(sweep_hit && held_q && !out_free);
				if (adv && sweep_hit && held_q) begin
					push  = 1'b1;
					pkind = KIND_TIMEOUT;
					ptag  = held_tag_q;
					pstat = tstat_q;
				end
				if (links[TABLE_DEPTH].act) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				unique case (op_q)
					OP_SEND: begin
						if (out_free) begin
							push    = 1'b1;
							plast   = 1'b1;
							state_d = ST_IDLE;
							if (refused_q) begin
								pkind = KIND_REFUSED;
							end else begin
								pkind    = KIND_ISSUED;
								ptag     = next_tag_q;
								papi     = api_q;
								bump_tag = 1'b1;
							end
						end
					end
					OP_RESPONSE: begin
						if (out_free) begin
							push    = 1'b1;
							plast   = 1'b1;
							ptag    = rid_q;
							state_d = ST_IDLE;
							if (found_q) begin
								pkind = KIND_COMPLETED;
								pstat = rstat_q;
							end else begin
								pkind     = KIND_DROPPED;
								pdrop     = drop_q + WORD_W'(1);
								bump_drop = 1'b1;
							end
						end
					end
					OP_SWEEP: begin
						if (!held_q) begin
							state_d = ST_IDLE;
						end else if (out_free) begin
							push    = 1'b1;
							plast   = 1'b1;
							pkind   = KIND_TIMEOUT;
							ptag    = held_tag_q;
							pstat   = tstat_q;
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act0_q     <= 1'b0;
			held_q     <= 1'b0;
			count_q    <= '0;
			next_tag_q <= '0;
			drop_q     <= '0;
			ovalid_q   <= 1'b0;
			limit_q    <= LIMIT_RST;
			tmo_q      <= TIMEOUT_RST;
			tstat_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				act0_q <= 1'b1;
				held_q <= 1'b0;
			end else if (adv) begin
				act0_q <= 1'b0;
				if (sweep_hit) begin
					held_q <= 1'b1;
				end
			end
			if (adv && hit_any) begin
				if (op_q == OP_SEND) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (bump_tag) begin
				next_tag_q <= next_tag_q + WORD_W'(1);
			end
			if (bump_drop) begin
				drop_q <= drop_q + WORD_W'(1);
			end
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			// register writes
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_PENDING_LIMIT:  limit_q <= cfg.data[LIMIT_W-1:0];
					CFG_TIMEOUT_TICKS:  tmo_q   <= cfg.data[TICK_W-1:0];
					CFG_TIMEOUT_STATUS: tstat_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// item payload, held result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(req.opcode);
			api_q     <= req.api_code;
			rid_q     <= req.request_id;
			rstat_q   <= req.response_status;
			now_q     <= req.timestamp;
			dl_q      <= req.timestamp + {1'b0, tmo_q};
			refused_q <= refuse_now;
		end
		if (state_q == ST_SCAN && links[TABLE_DEPTH].act) begin
			found_q <= links[TABLE_DEPTH].taken;
		end
		if (adv && sweep_hit) begin
			held_tag_q <= hit_tag;
		end
		if (push) begin
			okind_q <= pkind;
			otag_q  <= ptag;
			oapi_q  <= papi;
			ostat_q <= pstat;
			odrop_q <= pdrop;
			olast_q <= plast;
		end
	end

	assign rsp.valid         = ovalid_q;
	assign rsp.kind          = okind_q;
	assign rsp.tag_id        = otag_q;
	assign rsp.issued_api    = oapi_q;
	assign rsp.result_status = ostat_q;
	assign rsp.drop_total    = odrop_q;
	assign rsp.last_of_run   = olast_q;

endmodule
